>>> rtl/ssg_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ssg_pkg
// Shared types and codes for the sweep square sound generator.
// ----------------------------------------------------------------------------
package ssg_pkg;

  // op codes
  localparam logic OP_TICK  = 1'b0;
  localparam logic OP_START = 1'b1;

  // wave modes
  localparam logic MODE_PHASE  = 1'b0;
  localparam logic MODE_PERIOD = 1'b1;

  typedef struct packed {
    logic              op;
    logic              wave_mode;
    logic        [7:0] base_frequency;
    logic signed [7:0] init_slide;
    logic signed [7:0] slide_accel;
    logic        [2:0] duty_select;
    logic        [7:0] pulse_frequency;
    logic       [10:0] duration;
  } ssg_in_t;

  typedef struct packed {
    logic speaker_level;
    logic sound_active;
  } ssg_out_t;

  // control from the pipeline to the engine
  typedef struct packed {
    logic step;
    logic enable;
  } ssg_ctrl_t;

endpackage

>>> rtl/ssg_engine.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ssg_engine
// Oscillator state and the single-pass update for one start or tick word.
// ----------------------------------------------------------------------------
module ssg_engine (
  input  logic              clk,
  input  logic              rst,
  input  ssg_pkg::ssg_ctrl_t ctrl,
  input  ssg_pkg::ssg_in_t  item,
  output ssg_pkg::ssg_out_t result
);
  import ssg_pkg::*;

  logic [15:0] phase_a, phase_b, ticks_left, pitch_a, pitch_b;
  logic [15:0] slide_rate, slide_change;
  logic        active_mode, pin_level;

  logic [15:0] phase_a_next, phase_b_next, ticks_left_next, pitch_a_next, pitch_b_next;
  logic [15:0] slide_rate_next, slide_change_next;
  logic        active_mode_next, pin_level_next;

  // tick path
  logic [15:0] t_slide, t_pa, t_pb, t_sa, t_sb;
  logic        t_tog_a, t_tog_b;

  // start path
  logic [15:0] s_slide, s_accel, s_pa0, s_pitch_a, s_phase_b;
  logic [7:0]  s_hi;
  logic [10:0] s_prod;

  always_comb begin
    t_slide = (ticks_left[7:0] == 8'd0) ? slide_rate + slide_change : slide_rate;
    t_pa    = pitch_a + t_slide;
    t_pb    = pitch_b + t_slide;
    if (active_mode == MODE_PHASE) begin
      t_sa    = phase_a + t_pa;
      t_sb    = phase_b + t_pb;
      t_tog_a = t_sa[15];
      t_tog_b = t_sb[15];
      t_sa[15] = 1'b0;
      t_sb[15] = 1'b0;
    end else begin
      t_sa    = phase_a + 16'd1;
      t_sb    = phase_b + 16'd1;
      t_tog_a = t_sa > (t_pa >> 5);
      t_tog_b = t_sb > (t_pb >> 5);
      if (t_tog_a) t_sa = 16'd0;
      if (t_tog_b) t_sb = 16'd0;
    end
  end

  always_comb begin
    s_slide = {{8{item.init_slide[7]}}, item.init_slide};
    s_accel = {{8{item.slide_accel[7]}}, item.slide_accel};
    s_hi    = 8'h80 + {1'b0, ({1'b0, item.duty_select} + 4'd1), 3'b000};
    s_pa0   = 16'd32 - {8'd0, item.base_frequency};
    s_prod  = 11'(3'd7 - item.duty_select) * {3'd0, item.base_frequency};
    if (item.wave_mode == MODE_PHASE) begin
      s_pitch_a = {2'b00, item.base_frequency, 6'd0};
      s_phase_b = {s_hi, 8'd0};
    end else begin
      s_pitch_a = {s_pa0[9:0], 6'd0};
      s_phase_b = s_pa0 + {8'd0, s_prod[10:3]};
      s_slide   = 16'd0 - s_slide;
      s_accel   = 16'd0 - s_accel;
    end
  end

  always_comb begin
    phase_a_next      = phase_a;
    phase_b_next      = phase_b;
    ticks_left_next   = ticks_left;
    pitch_a_next      = pitch_a;
    pitch_b_next      = pitch_b;
    slide_rate_next   = slide_rate;
    slide_change_next = slide_change;
    active_mode_next  = active_mode;
    pin_level_next    = pin_level;
    if (item.op == OP_START) begin
      if (ctrl.enable) begin
        phase_a_next      = 16'd0;
        phase_b_next      = s_phase_b;
        pitch_a_next      = s_pitch_a;
        pitch_b_next      = s_pitch_a + {6'd0, item.pulse_frequency, 2'b00};
        slide_rate_next   = s_slide;
        slide_change_next = s_accel;
        ticks_left_next   = {item.duration, 5'd0};
        active_mode_next  = item.wave_mode;
      end
    end else if (ticks_left == 16'd0) begin
      pin_level_next = 1'b0;
    end else begin
      slide_rate_next = t_slide;
      pitch_a_next    = t_pa;
      pitch_b_next    = t_pb;
      phase_a_next    = t_sa;
      phase_b_next    = t_sb;
      pin_level_next  = pin_level ^ t_tog_a ^ t_tog_b;
      ticks_left_next = ticks_left - 16'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase_a      <= '0;
      phase_b      <= '0;
      ticks_left   <= '0;
      pitch_a      <= '0;
      pitch_b      <= '0;
      slide_rate   <= '0;
      slide_change <= '0;
      active_mode  <= 1'b0;
      pin_level    <= 1'b0;
    end else if (ctrl.step) begin
      phase_a      <= phase_a_next;
      phase_b      <= phase_b_next;
      ticks_left   <= ticks_left_next;
      pitch_a      <= pitch_a_next;
      pitch_b      <= pitch_b_next;
      slide_rate   <= slide_rate_next;
      slide_change <= slide_change_next;
      active_mode  <= active_mode_next;
      pin_level    <= pin_level_next;
    end
  end

  assign result.speaker_level = pin_level_next;
  assign result.sound_active  = (ticks_left_next != 16'd0);

`ifndef NO_ASSERTIONS
  a_silent_low: assert property (@(posedge clk) disable iff (rst)
    (ctrl.step && item.op == OP_TICK && ticks_left == 16'd0) |=> !pin_level)
    else $error("speaker not low after tick with no sound");

  a_tick_count: assert property (@(posedge clk) disable iff (rst)
    (ctrl.step && item.op == OP_TICK && ticks_left != 16'd0)
      |=> ticks_left == 16'($past(ticks_left) - 16'd1))
    else $error("tick count did not decrement");

  a_disabled_start: assert property (@(posedge clk) disable iff (rst)
    (ctrl.step && item.op == OP_START && !ctrl.enable)
      |=> $stable(ticks_left) && $stable(pitch_a) && $stable(pin_level))
    else $error("start taken while disabled");

  a_hold: assert property (@(posedge clk) disable iff (rst)
    !ctrl.step |=> $stable(ticks_left) && $stable(phase_a) && $stable(pin_level))
    else $error("state moved without a word");
`endif

endmodule

>>> rtl/sweep_square_sound_generator_core.sv
`timescale 1ns / 1ps
// A result word is written to the result register after its command word passes the input register.
// Throughput: one command word per cycle unless rsp_stall holds it; the state update
// is one pass of 16-bit adds and compares between the input and result registers.
// Reset (synchronous, active high) clears all oscillator state, the enable register
// and both valid flags.
// ----------------------------------------------------------------------------
// sweep_square_sound_generator_core
// Input register, engine update and result register with valid/stall handshake.
// ----------------------------------------------------------------------------
module sweep_square_sound_generator_core (
  input  logic              clk,
  input  logic              rst,
  input  logic              cmd_valid,
  output logic              cmd_stall,
  input  ssg_pkg::ssg_in_t  cmd,
  output logic              rsp_valid,
  input  logic              rsp_stall,
  output ssg_pkg::ssg_out_t rsp,
  input  logic              cfg_valid,
  output logic              cfg_ready,
  input  logic              cfg_data
);
  import ssg_pkg::*;

  logic      hold_valid;
  ssg_in_t   hold;
  logic      sound_enable;
  logic      advance;
  ssg_ctrl_t ctrl;
  ssg_out_t  result;

  assign advance   = !rsp_valid || !rsp_stall;
  assign cmd_stall = hold_valid && !advance;
  assign cfg_ready = 1'b1;

  assign ctrl.step   = hold_valid && advance;
  assign ctrl.enable = sound_enable;

  always_ff @(posedge clk) begin
    if (rst) begin
      sound_enable <= 1'b0;
    end else if (cfg_valid && cfg_ready) begin
      sound_enable <= cfg_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      hold_valid <= 1'b0;
    end else if (!cmd_stall) begin
      hold_valid <= cmd_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (!cmd_stall && cmd_valid) begin
      hold <= cmd;
    end
  end

  ssg_engine u_engine (
    .clk    (clk),
    .rst    (rst),
    .ctrl   (ctrl),
    .item   (hold),
    .result (result)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      rsp_valid <= 1'b0;
    end else if (advance) begin
      rsp_valid <= hold_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (ctrl.step) begin
      rsp <= result;
    end
  end

endmodule

>>> dv/tb_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the sweep square sound generator core. A scoreboard
// object carries its own copy of the oscillator state, computes the speaker
// level and activity flag for every accepted command word and checks each
// response word against the oldest prediction. Directed corner words come
// first, then random start/tick sequences under several idle and stall mixes.
// ----------------------------------------------------------------------------
module tb_top;
  import ssg_pkg::*;

  class tone_scoreboard;
    bit [15:0] phase_a, phase_b, ticks_left, pitch_a, pitch_b;
    bit [15:0] slide_rate, slide_change;
    bit        wave_sel, pin, enabled;
    ssg_out_t  levels_due[$];
    int        errors;

    function void set_enable(bit v);
      enabled = v;
    endfunction

    function int pending();
      return levels_due.size();
    endfunction

    task report(string what);
      $display("%0t ns: response error: %s", $time, what);
      errors++;
    endtask

    function void load_sound(ssg_in_t w);
      bit [15:0] freq, slide, accel, pw, pf, hi;
      freq  = {8'd0, w.base_frequency};
      slide = {{8{w.init_slide[7]}}, w.init_slide};
      accel = {{8{w.slide_accel[7]}}, w.slide_accel};
      pw    = {13'd0, w.duty_select};
      pf    = {8'd0, w.pulse_frequency};
      hi    = 16'h0080 + ((pw + 16'd1) << 3);
      phase_a  = '0;
      phase_b  = {hi[7:0], 8'h00};
      wave_sel = w.wave_mode;
      if (w.wave_mode == MODE_PHASE) begin
        pitch_a      = freq << 6;
        slide_rate   = slide;
        slide_change = accel;
      end else begin
        pitch_a      = 16'd32 - freq;
        phase_b      = pitch_a + ((16'd7 - pw) * freq) / 16'd8;
        pitch_a      = pitch_a << 6;
        slide_rate   = 16'd0 - slide;
        slide_change = 16'd0 - accel;
      end
      pitch_b    = pitch_a + (pf << 2);
      ticks_left = {w.duration, 5'd0};
    endfunction

    function void advance_tick();
      if (ticks_left == 16'd0) begin
        pin = 1'b0;
        return;
      end
      // sweep acceleration lands every 256 ticks
      if (ticks_left[7:0] == 8'd0) slide_rate = slide_rate + slide_change;
      pitch_a = pitch_a + slide_rate;
      pitch_b = pitch_b + slide_rate;
      if (wave_sel == MODE_PHASE) begin
        phase_a = phase_a + pitch_a;
        if (phase_a[15]) begin
          phase_a[15] = 1'b0;
          pin = ~pin;
        end
        phase_b = phase_b + pitch_b;
        if (phase_b[15]) begin
          phase_b[15] = 1'b0;
          pin = ~pin;
        end
      end else begin
        phase_a = phase_a + 16'd1;
        if (phase_a > (pitch_a >> 5)) begin
          phase_a = '0;
          pin = ~pin;
        end
        phase_b = phase_b + 16'd1;
        if (phase_b > (pitch_b >> 5)) begin
          phase_b = '0;
          pin = ~pin;
        end
      end
      ticks_left = ticks_left - 16'd1;
    endfunction

    function void note_command(ssg_in_t w);
      ssg_out_t e;
      if (w.op == OP_START) begin
        if (enabled) load_sound(w);
      end else begin
        advance_tick();
      end
      e.speaker_level = pin;
      e.sound_active  = (ticks_left != 16'd0);
      levels_due.push_back(e);
    endfunction

    task check_level(ssg_out_t r);
      ssg_out_t e;
      if (levels_due.size() == 0) begin
        report($sformatf("unexpected word %b", r));
        return;
      end
      e = levels_due.pop_front();
      if (r.speaker_level !== e.speaker_level)
        report($sformatf("speaker_level got %b want %b", r.speaker_level, e.speaker_level));
      if (r.sound_active !== e.sound_active)
        report($sformatf("sound_active got %b want %b", r.sound_active, e.sound_active));
    endtask
  endclass

  logic     clk = 1'b0;
  logic     rst = 1'b1;
  logic     cmd_valid = 1'b0;
  logic     cmd_stall;
  ssg_in_t  cmd = '0;
  logic     rsp_valid;
  logic     rsp_stall = 1'b0;
  ssg_out_t rsp;
  logic     cfg_valid = 1'b0;
  logic     cfg_ready;
  logic     cfg_data = 1'b0;

  int  idle_pct = 0;
  int  stall_pct = 0;
  bit  holding = 1'b0;
  event hold_go;

  tone_scoreboard sb = new();

  sweep_square_sound_generator_core uut (
    .clk       (clk),
    .rst       (rst),
    .cmd_valid (cmd_valid),
    .cmd_stall (cmd_stall),
    .cmd       (cmd),
    .rsp_valid (rsp_valid),
    .rsp_stall (rsp_stall),
    .rsp       (rsp),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_data  (cfg_data)
  );

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  initial begin
    #5_000_000;
    $display("[FAIL] regression broken");
    $finish;
  end

  // long receiver hold-off so the pipeline backs up into the input
  initial forever begin
    @(hold_go);
    holding = 1'b1;
    repeat (200) @(negedge clk);
    holding = 1'b0;
  end

  always @(negedge clk) begin
    rsp_stall = holding || ($urandom_range(99) < stall_pct);
  end

  always @(posedge clk) begin
    if (!rst && rsp_valid && !rsp_stall) sb.check_level(rsp);
  end

  function automatic ssg_in_t rand_word();
    bit [63:0] r;
    r = {$urandom, $urandom};
    return r[47:0];
  endfunction

  function automatic ssg_in_t tick_word();
    ssg_in_t w;
    w = rand_word();
    w.op = OP_TICK;
    return w;
  endfunction

  function automatic ssg_in_t start_word(input logic m, input logic [7:0] f,
                                         input logic [7:0] s, input logic [7:0] a,
                                         input logic [2:0] pw, input logic [7:0] pf,
                                         input logic [10:0] d);
    ssg_in_t w;
    w.op = OP_START;
    w.wave_mode = m;
    w.base_frequency = f;
    w.init_slide = s;
    w.slide_accel = a;
    w.duty_select = pw;
    w.pulse_frequency = pf;
    w.duration = d;
    return w;
  endfunction

  // called and returns at a falling edge
  task automatic send_word(input ssg_in_t w);
    while ($urandom_range(99) < idle_pct) begin
      cmd_valid = 1'b0;
      @(negedge clk);
    end
    cmd_valid = 1'b1;
    cmd = w;
    do @(posedge clk); while (cmd_stall);
    sb.note_command(w);
    @(negedge clk);
  endtask

  task automatic settle();
    cmd_valid = 1'b0;
    while (sb.pending() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
    @(negedge clk);
  endtask

  task automatic write_enable(input bit v);
    cfg_valid = 1'b1;
    cfg_data = v;
    do @(posedge clk); while (!cfg_ready);
    sb.set_enable(v);
    @(negedge clk);
    cfg_valid = 1'b0;
  endtask

  task automatic send_ticks(input int n);
    repeat (n) send_word(tick_word());
  endtask

  task automatic directed_words();
    // start while disabled is dropped; tick on an idle generator holds pin low
    send_word(start_word(MODE_PHASE, 8'd100, 8'sd5, 8'sd1, 3'd3, 8'd10, 11'd5));
    send_ticks(1);
    settle();
    write_enable(1'b1);
    send_word(start_word(MODE_PHASE, 8'd255, 8'sh7f, 8'sh80, 3'd7, 8'd255, 11'd2047));
    send_ticks(3);
    send_word(start_word(MODE_PERIOD, 8'd0, 8'sh80, 8'sh7f, 3'd0, 8'd0, 11'd1));
    send_ticks(5);
    // duration 8 puts the first tick on a sweep boundary
    send_word(start_word(MODE_PERIOD, 8'd255, 8'sh7f, 8'sh80, 3'd7, 8'd255, 11'd8));
    send_ticks(3);
    // zero duration: silent at once
    send_word(start_word(MODE_PHASE, 8'd0, 8'sh80, 8'sh7f, 3'd0, 8'd0, 11'd0));
    send_ticks(2);
    send_word(start_word(MODE_PERIOD, 8'd32, 8'sd0, 8'sd0, 3'd4, 8'd1, 11'd1));
    send_ticks(3);
  endtask

  task automatic play_sequence(output int n);
    ssg_in_t w;
    int      pick, nticks;
    n = 0;
    pick = $urandom_range(99);
    if (pick < 15) begin
      send_word(rand_word());
      n = 1;
      return;
    end
    w = rand_word();
    w.op = OP_START;
    pick = $urandom_range(99);
    if (pick < 55)      w.duration = 11'($urandom_range(0, 3));
    else if (pick < 80) w.duration = 11'($urandom_range(4, 9));
    else if (pick < 92) w.duration = 11'($urandom_range(0, 2047));
    else                w.duration = 11'($urandom_range(2040, 2047));
    if (w.duration <= 9) nticks = w.duration * 32 + $urandom_range(0, 6);
    else                 nticks = $urandom_range(1, 40);
    if (nticks > 300) nticks = 300;
    send_word(w);
    send_ticks(nticks);
    n = nticks + 1;
  endtask

  task automatic run_phase(input int idle, input int stall, input bit en,
                           input int count, input bit hold);
    int sent, n;
    settle();
    write_enable(en);
    idle_pct = idle;
    stall_pct = stall;
    if (hold) -> hold_go;
    sent = 0;
    while (sent < count) begin
      play_sequence(n);
      sent += n;
    end
  endtask

  initial begin
    repeat (12) @(negedge clk);
    rst = 1'b0;
    directed_words();
    run_phase(0, 0, 1'b1, 250, 1'b0);
    run_phase(83, 0, 1'b1, 200, 1'b0);
    run_phase(0, 83, 1'b1, 200, 1'b0);
    run_phase(13, 13, 1'b0, 100, 1'b0);
    run_phase(13, 13, 1'b1, 200, 1'b0);
    run_phase(0, 0, 1'b1, 250, 1'b1);
    settle();
    repeat (8) @(posedge clk);
    if (sb.errors == 0 && sb.pending() == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule
